// ===== rtl/mvts_pkg.sv =====
// mvts_pkg: shared constants, opcodes and structs of the tone sequencer
// used by mvts_voice and multi_voice_tone_sequencer; no dependencies
package mvts_pkg;

   localparam int VOICES     = 5;
   localparam int NOTE_DEPTH = 256;
   localparam int IDX_W      = $clog2(NOTE_DEPTH);

   localparam int US_PER_MS  = 1000;
   localparam int PRESC_W    = 10;

   // field widths
   localparam int OPCODE_W   = 2;
   localparam int VOICE_W    = 3;
   localparam int NIDX_W     = 8;
   localparam int HALF_W     = 16;
   localparam int DUR_W      = 16;
   localparam int ENTRY_W    = HALF_W + DUR_W;
   localparam int TLEN_W     = 10;
   localparam int SLEN_W     = 9;
   localparam int GAP_W      = 10;
   localparam int MASK_W     = 5;
   localparam int DURMS_W    = DUR_W + TLEN_W;

   // req_tdata layout, lowest field first
   localparam int REQ_VOICE_LSB = 0;
   localparam int REQ_NIDX_LSB  = REQ_VOICE_LSB + VOICE_W;
   localparam int REQ_HALF_LSB  = REQ_NIDX_LSB + NIDX_W;
   localparam int REQ_DUR_LSB   = REQ_HALF_LSB + HALF_W;
   localparam int REQ_USED_W    = REQ_DUR_LSB + DUR_W;
   localparam int REQ_DATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   // rsp_tdata layout
   localparam int RSP_USED_W    = 2 * MASK_W;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   // configuration port
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 10;

   localparam logic [TLEN_W-1:0] TLEN_RESET = TLEN_W'(100);
   localparam logic [SLEN_W-1:0] SLEN_RESET = SLEN_W'(256);
   localparam logic [GAP_W-1:0]  GAP_RESET  = GAP_W'(750);
   localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICK_LEN  = 2'd0,
      CSR_SONG_LEN  = 2'd1,
      CSR_GAP_TICKS = 2'd2,
      CSR_GAP_MASK  = 2'd3
   } mvts_csr_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK  = 2'd0,
      OP_LOAD  = 2'd1,
      OP_START = 2'd2
   } mvts_op_type;

   // shared controls from the top level to each voice lane
   typedef struct packed {
      logic               tick;
      logic               start;
      logic               ms_edge;
      logic [IDX_W-1:0]   load_idx;
      logic [HALF_W-1:0]  load_half;
      logic [DUR_W-1:0]   load_dur;
      logic [TLEN_W-1:0]  tick_len;
      logic [SLEN_W-1:0]  song_len;
      logic [GAP_W-1:0]   gap_ticks;
   } mvts_ctl_type;

   // per-voice result of the item being accepted
   typedef struct packed {
      logic level;
      logic advanced;
   } mvts_stat_type;

endpackage

// ===== rtl/mvts_ram.sv =====
// mvts_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module mvts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/mvts_voice.sv =====
// mvts_voice: one voice lane, its note bank and its play counters
// depends on mvts_pkg and mvts_ram
module mvts_voice (
   input  logic                  clock,
   input  logic                  reset,
   input  mvts_pkg::mvts_ctl_type ctl,
   input  logic                  load_we,
   input  logic                  gap_en,
   output mvts_pkg::mvts_stat_type stat
);

   localparam int IDX_W   = mvts_pkg::IDX_W;
   localparam int HALF_W  = mvts_pkg::HALF_W;
   localparam int DUR_W   = mvts_pkg::DUR_W;
   localparam int DURMS_W = mvts_pkg::DURMS_W;
   localparam int GAP_W   = mvts_pkg::GAP_W;
   localparam int SLEN_W  = mvts_pkg::SLEN_W;
   localparam int NXT_W   = IDX_W + 1;
   localparam int CMP_W   = (NXT_W > SLEN_W) ? NXT_W : SLEN_W;

   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [HALF_W-1:0]  per_ff, per_in;
   logic [DURMS_W-1:0] dur_ff, dur_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   logic               level_ff, level_in;
   logic [HALF_W-1:0]  half_ff, half_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               dur_pend_ff, dur_pend_in;
   logic               per_pend_ff, per_pend_in;

   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;
   logic [mvts_pkg::ENTRY_W-1:0] rd_data;
   logic [HALF_W-1:0]           rd_half;
   logic [DUR_W-1:0]            rd_dur;

   logic [HALF_W-1:0]  eff_half;
   logic [HALF_W-1:0]  eff_per;
   logic [DURMS_W-1:0] prod;
   logic [DURMS_W-1:0] eff_dur;
   logic [DURMS_W-1:0] dur_dec;
   logic               eff_dur_zero;
   logic               eff_dur_one;
   logic               adv;
   logic               expire;
   logic [NXT_W-1:0]   nxt;
   logic               wrap;
   logic [IDX_W-1:0]   next_pos;
   logic [GAP_W-1:0]   gap_a;
   logic               load_hit;

   mvts_ram #(
      .WIDTH (mvts_pkg::ENTRY_W),
      .DEPTH (mvts_pkg::NOTE_DEPTH)
   ) u_bank (
      .clock (clock),
      .we    (load_we),
      .waddr (ctl.load_idx),
      .wdata ({ctl.load_dur, ctl.load_half}),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   assign rd_half = rd_data[HALF_W-1:0];
   assign rd_dur  = rd_data[mvts_pkg::ENTRY_W-1:HALF_W];

   // entry fetched last cycle lands here: forward it instead of the cached copy
   assign eff_half = rd_pend_ff ? rd_half : half_ff;
   assign eff_per  = per_pend_ff ? rd_half : per_ff;
   assign prod     = DURMS_W'({{mvts_pkg::TLEN_W{1'b0}}, rd_dur}
                     * {{DUR_W{1'b0}}, ctl.tick_len});
   assign eff_dur  = dur_pend_ff ? prod : dur_ff;

   // zero and one tests without waiting on the product
   assign eff_dur_zero = dur_pend_ff ? (rd_dur == '0 || ctl.tick_len == '0)
                                     : (dur_ff == '0);
   assign eff_dur_one  = dur_pend_ff ? (rd_dur == DUR_W'(1) &&
                                        ctl.tick_len == mvts_pkg::TLEN_W'(1))
                                     : (dur_ff == DURMS_W'(1));

   assign dur_dec = (ctl.ms_edge && !eff_dur_zero) ? eff_dur - DURMS_W'(1) : eff_dur;
   assign adv     = eff_dur_zero || (ctl.ms_edge && eff_dur_one);
   assign expire  = (eff_per <= HALF_W'(1));

   assign nxt      = NXT_W'(pos_ff) + NXT_W'(1);
   assign wrap     = (CMP_W'(nxt) >= CMP_W'(ctl.song_len)) ||
                     (nxt >= NXT_W'(mvts_pkg::NOTE_DEPTH));
   assign next_pos = wrap ? '0 : nxt[IDX_W-1:0];

   assign gap_a    = (adv && gap_en) ? GAP_W'(1) : gap_ff;
   assign load_hit = load_we && (ctl.load_idx == pos_ff);
   assign rd_addr  = ctl.start ? '0 : next_pos;

   always_comb begin
      pos_in      = pos_ff;
      dur_in      = eff_dur;
      dur_pend_in = 1'b0;
      per_in      = eff_per;
      per_pend_in = 1'b0;
      gap_in      = gap_ff;
      level_in    = level_ff;
      half_in     = eff_half;
      rd_pend_in  = 1'b0;
      rd_en       = 1'b0;
      if (ctl.tick) begin
         gap_in = gap_a;
         if (adv) begin
            pos_in      = next_pos;
            rd_en       = 1'b1;
            rd_pend_in  = 1'b1;
            dur_pend_in = 1'b1;
         end else begin
            dur_in = dur_dec;
         end
         if (expire) begin
            if (gap_a != '0) begin
               // each expiry inside the gap counts, counter stays at zero
               gap_in = (gap_a >= ctl.gap_ticks) ? '0 : gap_a + GAP_W'(1);
               per_in = '0;
            end else begin
               level_in = ~level_ff;
               if (adv) begin
                  per_pend_in = 1'b1;
               end else begin
                  per_in = eff_half;
               end
            end
         end else begin
            per_in = eff_per - HALF_W'(1);
         end
      end else if (ctl.start) begin
         pos_in      = '0;
         rd_en       = 1'b1;
         rd_pend_in  = 1'b1;
         dur_pend_in = 1'b1;
         per_pend_in = 1'b1;
         gap_in      = '0;
         level_in    = 1'b0;
      end else if (load_hit) begin
         half_in = ctl.load_half;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         per_ff      <= '0;
         dur_ff      <= '0;
         gap_ff      <= '0;
         level_ff    <= 1'b0;
         rd_pend_ff  <= 1'b0;
         dur_pend_ff <= 1'b0;
         per_pend_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         per_ff      <= per_in;
         dur_ff      <= dur_in;
         gap_ff      <= gap_in;
         level_ff    <= level_in;
         rd_pend_ff  <= rd_pend_in;
         dur_pend_ff <= dur_pend_in;
         per_pend_ff <= per_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      half_ff <= half_in;
   end

   assign stat.level    = level_in;
   assign stat.advanced = ctl.tick && adv;

endmodule

// ===== rtl/multi_voice_tone_sequencer.sv =====
// multi_voice_tone_sequencer: five square-wave voices played from banked note memory
// depends on mvts_pkg, mvts_voice and mvts_ram
//
// req channel: tuser carries the opcode (tick, load, start), tdata the load
// fields. every transfer on req produces exactly one transfer on rsp carrying
// the output levels and the per-voice note change bits.
// a load writes one note entry of voice 0 to 4 (nothing for 5 to 7); a start puts every voice back
// to entry 0; a tick advances play time by one microsecond.
// throughput: one item per clock while rsp keeps up, back to back, any mix of opcodes.
// result: registered into the output slot, or into the skid slot while rsp is stalled.
// each voice owns a 256 x 32 note bank; an entry fetched on a note change
// comes from the registered read port and is forwarded into that voice's counters, so
// the bank read port sets no limit on the rate.
// csr writes take effect at the next edge and are meant for idle periods.
// reset: all voices at entry 0 with expired counters, levels low, registers
// at their defaults; note memory holds nothing useful until loaded, and no
// clearing pass runs.
// stall: a two-deep output buffer absorbs results; req_tready drops only
// while both slots are full.
module multi_voice_tone_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // voice, note_index, half_period_us, duration_ticks, zero pad
   input  logic [mvts_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode
   input  logic [mvts_pkg::OPCODE_W-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // motor_levels, note_advanced, zero pad
   output logic [mvts_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [mvts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mvts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int VOICES = mvts_pkg::VOICES;
   localparam int MASK_W = mvts_pkg::MASK_W;

   logic [mvts_pkg::TLEN_W-1:0]  tick_len_ff;
   logic [mvts_pkg::SLEN_W-1:0]  song_len_ff;
   logic [mvts_pkg::GAP_W-1:0]   gap_ticks_ff;
   logic [MASK_W-1:0]            gap_mask_ff;
   logic [mvts_pkg::PRESC_W-1:0] presc_ff, presc_in;

   logic                          req_xfer;
   logic                          rsp_xfer;
   logic                          is_tick, is_load, is_start;
   logic [mvts_pkg::VOICE_W-1:0]  load_voice;
   logic [mvts_pkg::NIDX_W-1:0]   load_nidx;
   logic                          load_ok;
   mvts_pkg::mvts_ctl_type        ctl;
   logic [VOICES-1:0]             load_we;
   mvts_pkg::mvts_stat_type       stat [VOICES];
   logic [MASK_W-1:0]             levels;
   logic [MASK_W-1:0]             advanced;
   logic [mvts_pkg::RSP_DATA_W-1:0] result;

   logic                            rsp_valid_ff;
   logic [mvts_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                            skid_valid_ff;
   logic [mvts_pkg::RSP_DATA_W-1:0] skid_data_ff;

   assign req_tready = !skid_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;

   always_comb begin
      is_tick  = 1'b0;
      is_load  = 1'b0;
      is_start = 1'b0;
      case (mvts_pkg::mvts_op_type'(req_tuser))
         mvts_pkg::OP_TICK:  is_tick  = req_xfer;
         mvts_pkg::OP_LOAD:  is_load  = req_xfer;
         mvts_pkg::OP_START: is_start = req_xfer;
         default: ;
      endcase
   end

   assign load_voice = req_tdata[mvts_pkg::REQ_VOICE_LSB +: mvts_pkg::VOICE_W];
   assign load_nidx  = req_tdata[mvts_pkg::REQ_NIDX_LSB +: mvts_pkg::NIDX_W];
   assign load_ok    = (int'(load_nidx) < mvts_pkg::NOTE_DEPTH);

   // microsecond prescaler, the wrap marks a millisecond
   assign ctl.ms_edge = (presc_ff >= mvts_pkg::PRESC_W'(mvts_pkg::US_PER_MS - 1));

   always_comb begin
      presc_in = presc_ff;
      if (is_start) begin
         presc_in = '0;
      end else if (is_tick) begin
         presc_in = ctl.ms_edge ? '0 : presc_ff + mvts_pkg::PRESC_W'(1);
      end
   end

   assign ctl.tick      = is_tick;
   assign ctl.start     = is_start;
   assign ctl.load_idx  = mvts_pkg::IDX_W'(load_nidx);
   assign ctl.load_half = req_tdata[mvts_pkg::REQ_HALF_LSB +: mvts_pkg::HALF_W];
   assign ctl.load_dur  = req_tdata[mvts_pkg::REQ_DUR_LSB +: mvts_pkg::DUR_W];
   assign ctl.tick_len  = tick_len_ff;
   assign ctl.song_len  = song_len_ff;
   assign ctl.gap_ticks = gap_ticks_ff;

   for (genvar gv = 0; gv < VOICES; gv++) begin : g_voice
      assign load_we[gv] = is_load && load_ok &&
                           (load_voice == mvts_pkg::VOICE_W'(gv));

      mvts_voice u_voice (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .load_we (load_we[gv]),
         .gap_en  (gap_mask_ff[gv]),
         .stat    (stat[gv])
      );
   end

   always_comb begin
      levels   = '0;
      advanced = '0;
      for (int i = 0; i < VOICES; i++) begin
         levels[i]   = stat[i].level;
         advanced[i] = stat[i].advanced;
      end
   end

   assign result = mvts_pkg::RSP_DATA_W'({advanced, levels});

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_len_ff  <= mvts_pkg::TLEN_RESET;
         song_len_ff  <= mvts_pkg::SLEN_RESET;
         gap_ticks_ff <= mvts_pkg::GAP_RESET;
         gap_mask_ff  <= mvts_pkg::MASK_RESET;
      end else if (csr_we) begin
         case (mvts_pkg::mvts_csr_type'(csr_index))
            mvts_pkg::CSR_TICK_LEN:  tick_len_ff  <= mvts_pkg::TLEN_W'(csr_wdata);
            mvts_pkg::CSR_SONG_LEN:  song_len_ff  <= mvts_pkg::SLEN_W'(csr_wdata);
            mvts_pkg::CSR_GAP_TICKS: gap_ticks_ff <= mvts_pkg::GAP_W'(csr_wdata);
            mvts_pkg::CSR_GAP_MASK:  gap_mask_ff  <= MASK_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_ff <= '0;
      end else begin
         presc_ff <= presc_in;
      end
   end

   // output register plus skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_xfer) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_xfer) begin
         if (!rsp_valid_ff || rsp_xfer) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_xfer) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (req_xfer) begin
         if (!rsp_valid_ff || rsp_xfer) begin
            rsp_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot holds a result while the output slot is empty");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("accepted item left no result on rsp");

   a_presc_range: assert property (@(posedge clock) disable iff (reset)
      presc_ff < mvts_pkg::PRESC_W'(mvts_pkg::US_PER_MS))
      else $error("microsecond prescaler ran past one millisecond");

   a_no_adv_off_tick: assert property (@(posedge clock) disable iff (reset)
      !is_tick |-> (advanced == '0))
      else $error("note change flagged on an item that is not a tick");

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for multi_voice_tone_sequencer, directed items then random phases
// depends on mvts_pkg and the rtl top level; a scoreboard class predicts every rsp transfer
`timescale 1ns / 1ps

module tb;
   import mvts_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int MAX_REPORTS = 100;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [VOICE_W-1:0]  voice;
      logic [NIDX_W-1:0]   nidx;
      logic [HALF_W-1:0]   half;
      logic [DUR_W-1:0]    dur;
   } tone_req_t;

   typedef struct {
      logic [MASK_W-1:0] levels;
      logic [MASK_W-1:0] advanced;
   } tone_rsp_t;

   class tone_scoreboard;
      logic [ENTRY_W-1:0] bank [VOICES][NOTE_DEPTH];
      bit                 loaded [VOICES][NOTE_DEPTH];
      logic [IDX_W-1:0]   pos [VOICES];
      logic [HALF_W-1:0]  period_left [VOICES];
      logic [DURMS_W-1:0] dur_left [VOICES];
      logic [GAP_W-1:0]   gap_cnt [VOICES];
      logic [VOICES-1:0]  level;
      logic [PRESC_W-1:0] presc;
      logic [TLEN_W-1:0]  tick_len;
      logic [SLEN_W-1:0]  song_len;
      logic [GAP_W-1:0]   gap_len;
      logic [MASK_W-1:0]  gap_mask;
      tone_rsp_t          expected_q [$];
      int errors, requests, results, note_changes, toggles, ms_wraps;

      function new();
         foreach (pos[v]) begin
            pos[v] = '0;
            period_left[v] = '0;
            dur_left[v] = '0;
            gap_cnt[v] = '0;
         end
         level = '0;
         presc = '0;
         tick_len = TLEN_RESET;
         song_len = SLEN_RESET;
         gap_len = GAP_RESET;
         gap_mask = MASK_RESET;
      endfunction

      function void write_reg(mvts_csr_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_TICK_LEN:  tick_len = val[TLEN_W-1:0];
            CSR_SONG_LEN:  song_len = val[SLEN_W-1:0];
            CSR_GAP_TICKS: gap_len = val[GAP_W-1:0];
            CSR_GAP_MASK:  gap_mask = val[MASK_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [DURMS_W-1:0] dur_ms(logic [ENTRY_W-1:0] e);
         return DURMS_W'(e[ENTRY_W-1:HALF_W]) * DURMS_W'(tick_len);
      endfunction

      function int next_pos(int v);
         int n;
         n = int'(pos[v]) + 1;
         if (n >= int'(song_len) || n >= NOTE_DEPTH) n = 0;
         return n;
      endfunction

      // entry that the next tick or start would fetch but that was never loaded
      function bit needs_entry(logic [OPCODE_W-1:0] op, output int vo, output int io);
         logic [DURMS_W-1:0] d;
         bit wrap;
         int nxt;
         vo = 0;
         io = 0;
         if (op != OP_TICK && op != OP_START) return 0;
         wrap = presc >= PRESC_W'(US_PER_MS - 1);
         for (int v = 0; v < VOICES; v++) begin
            if (op == OP_START) begin
               nxt = 0;
            end else begin
               d = dur_left[v];
               if (wrap && d != 0) d = d - 1'b1;
               nxt = (d == 0) ? next_pos(v) : int'(pos[v]);
            end
            if (!loaded[v][nxt]) begin
               vo = v;
               io = nxt;
               return 1;
            end
         end
         return 0;
      endfunction

      function void note_request(tone_req_t it);
         tone_rsp_t r;
         bit wrap;
         r.advanced = '0;
         requests++;
         if (it.op == OP_LOAD) begin
            if (it.voice < VOICES && it.nidx < NOTE_DEPTH) begin
               bank[it.voice][it.nidx] = {it.dur, it.half};
               loaded[it.voice][it.nidx] = 1'b1;
            end
         end else if (it.op == OP_START) begin
            presc = '0;
            for (int v = 0; v < VOICES; v++) begin
               pos[v] = '0;
               period_left[v] = bank[v][0][HALF_W-1:0];
               dur_left[v] = dur_ms(bank[v][0]);
               gap_cnt[v] = '0;
               level[v] = 1'b0;
            end
         end else if (it.op == OP_TICK) begin
            wrap = presc >= PRESC_W'(US_PER_MS - 1);
            presc = wrap ? '0 : presc + 1'b1;
            if (wrap) ms_wraps++;
            // note changes first, all voices, then the half-period counters
            for (int v = 0; v < VOICES; v++) begin
               if (wrap && dur_left[v] != 0) dur_left[v] = dur_left[v] - 1'b1;
               if (dur_left[v] == 0) begin
                  pos[v] = IDX_W'(next_pos(v));
                  dur_left[v] = dur_ms(bank[v][pos[v]]);
                  if (gap_mask[v]) gap_cnt[v] = GAP_W'(1);
                  r.advanced[v] = 1'b1;
               end
            end
            for (int v = 0; v < VOICES; v++) begin
               if (period_left[v] != 0) period_left[v] = period_left[v] - 1'b1;
               if (period_left[v] == 0) begin
                  if (gap_cnt[v] != 0) begin
                     if (gap_cnt[v] >= gap_len) gap_cnt[v] = '0;
                     else gap_cnt[v] = gap_cnt[v] + 1'b1;
                  end else begin
                     level[v] = ~level[v];
                     period_left[v] = bank[v][pos[v]][HALF_W-1:0];
                     toggles++;
                  end
               end
            end
         end
         r.levels = level;
         expected_q.push_back(r);
      endfunction

      function void report(string what, logic [MASK_W-1:0] exp_v, logic [MASK_W-1:0] act_v);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %b actual %b", $time, what, exp_v, act_v);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] d);
         tone_rsp_t e;
         results++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: rsp transfer %h with nothing expected", $time, d);
            return;
         end
         e = expected_q.pop_front();
         note_changes += $countones(e.advanced);
         if (d[MASK_W-1:0] !== e.levels)
            report("motor_levels", e.levels, d[MASK_W-1:0]);
         if (d[2*MASK_W-1:MASK_W] !== e.advanced)
            report("note_advanced", e.advanced, d[2*MASK_W-1:MASK_W]);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [OPCODE_W-1:0]     req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   multi_voice_tone_sequencer uut (.*);

   tone_scoreboard sb = new();
   int tx_free = 0;
   int rx_hold = 0;
   int rx_free = 0;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: mostly ready, short and long stalls, and stretches without any
   always @(posedge clock) begin
      int r;
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else if (rx_free > 0) begin
         rx_free--;
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            rx_hold = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else if (r < 18) begin
            rx_hold = $urandom_range(10, 50);
            rsp_tready <= 1'b0;
         end else if (r < 25) begin
            rx_free = $urandom_range(30, 120);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   task automatic sender_gap();
      int r, n;
      n = 0;
      if (tx_free > 0) begin
         tx_free--;
         return;
      end
      r = $urandom_range(0, 99);
      if (r >= 60 && r < 90) n = $urandom_range(1, 3);
      else if (r >= 90 && r < 97) tx_free = $urandom_range(20, 80);
      else if (r >= 97) n = $urandom_range(10, 40);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // called right after a rising edge; returns at the edge of the transfer, or later when a random gap follows it
   task automatic send_item(tone_req_t it);
      req_tvalid <= 1'b1;
      req_tuser <= it.op;
      req_tdata <= REQ_DATA_W'({it.dur, it.half, it.nidx, it.voice});
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
      sender_gap();
   endtask

   function automatic tone_req_t make_req(logic [OPCODE_W-1:0] op, int voice, int nidx,
                                          logic [HALF_W-1:0] half, logic [DUR_W-1:0] dur);
      tone_req_t it;
      it.op = op;
      it.voice = VOICE_W'(voice);
      it.nidx = NIDX_W'(nidx);
      it.half = half;
      it.dur = dur;
      return it;
   endfunction

   function automatic tone_req_t load_item(int voice, int nidx);
      tone_req_t it;
      int r;
      it.op = OP_LOAD;
      it.voice = VOICE_W'(voice);
      it.nidx = NIDX_W'(nidx);
      r = $urandom_range(0, 99);
      if (r < 5) it.half = '0;
      else if (r < 45) it.half = HALF_W'($urandom_range(1, 8));
      else if (r < 75) it.half = HALF_W'($urandom_range(9, 64));
      else it.half = HALF_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 30) it.dur = '0;
      else if (r < 75) it.dur = DUR_W'($urandom_range(1, 3));
      else it.dur = DUR_W'($urandom);
      return it;
   endfunction

   function automatic tone_req_t random_item(bit with_start, int tick_pct);
      tone_req_t it;
      int r, hi, idx;
      // unused fields carry noise
      it.voice = VOICE_W'($urandom);
      it.nidx = NIDX_W'($urandom);
      it.half = HALF_W'($urandom);
      it.dur = DUR_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
         it.op = OP_TICK;
      end else begin
         r = $urandom_range(0, 99);
         hi = (sb.song_len == 0) ? 0 :
              ((int'(sb.song_len) > NOTE_DEPTH) ? NOTE_DEPTH : int'(sb.song_len)) - 1;
         idx = ($urandom_range(0, 99) < 70) ? $urandom_range(0, hi)
                                            : $urandom_range(0, NOTE_DEPTH - 1);
         if (r < 70) it = load_item($urandom_range(0, VOICES - 1), idx);
         else if (r < 80) it = load_item($urandom_range(VOICES, 2**VOICE_W - 1), idx);
         else if (r < 90) it.op = with_start ? OP_START : OP_TICK;
         else it.op = OP_UNUSED;
      end
      return it;
   endfunction

   // fill any entry the item would fetch before it goes out
   task automatic play(tone_req_t it);
      int v, idx;
      while (sb.needs_entry(it.op, v, idx)) send_item(load_item(v, idx));
      send_item(it);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(mvts_csr_type idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic write_regs(int tlen, int slen, int gap, int mask);
      wait_idle();
      csr_write(CSR_TICK_LEN, CSR_DATA_W'(tlen));
      csr_write(CSR_SONG_LEN, CSR_DATA_W'(slen));
      csr_write(CSR_GAP_TICKS, CSR_DATA_W'(gap));
      csr_write(CSR_GAP_MASK, CSR_DATA_W'(mask));
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(int n_items, bit with_start, int tick_pct, int hold_at);
      play(make_req(OP_START, 0, 0, '0, '0));
      for (int i = 0; i < n_items; i++) begin
         if (i == hold_at) wait_idle();
         play(random_item(with_start, tick_pct));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_regs(1, 4, 1, 31);

      // tick straight out of reset, then loads at the field extremes
      play(make_req(OP_TICK, 0, 0, '0, '0));
      play(make_req(OP_LOAD, 0, 0, 16'h0000, 16'h0000));
      play(make_req(OP_LOAD, 1, 0, 16'hffff, 16'hffff));
      play(make_req(OP_LOAD, 2, 0, 16'h0001, 16'h0001));
      play(make_req(OP_LOAD, 3, 0, 16'h0002, 16'h0000));
      play(make_req(OP_LOAD, 4, 0, 16'h0003, 16'h0002));
      play(make_req(OP_LOAD, 4, 255, 16'haaaa, 16'h5555));
      // out-of-range voices are dropped
      play(make_req(OP_LOAD, 7, 255, 16'hffff, 16'hffff));
      play(make_req(OP_LOAD, 5, 0, 16'h0001, 16'h0001));
      play(make_req(OP_UNUSED, 7, 255, 16'hffff, 16'hffff));
      play(make_req(OP_START, 0, 0, '0, '0));
      repeat (6) play(make_req(OP_TICK, 0, 0, '0, '0));
      play(make_req(OP_START, 7, 255, 16'hffff, 16'hffff));
      play(make_req(OP_TICK, 7, 255, 16'hffff, 16'hffff));

      run_phase(100, 1'b1, 75, -1);
      // tick-heavy run with no start after the opening one, paused once until every result is back
      write_regs(1, 3, 2, 5'b01010);
      run_phase(220, 1'b0, 97, 110);
      write_regs(1000, 256, 1023, 31);
      run_phase(60, 1'b1, 75, -1);
      write_regs(0, 0, 0, 0);
      run_phase(50, 1'b1, 75, -1);
      write_regs($urandom_range(0, 1023), $urandom_range(0, 511),
                 $urandom_range(0, 1023), $urandom_range(0, 31));
      run_phase(100, 1'b1, 75, -1);

      wait_idle();
      repeat (5) @(posedge clock);
      $display("%0d requests over five register settings, %0d responses checked, %0d cycles",
               sb.requests, sb.results, cycle_count);
      $display("%0d note changes, %0d level toggles, %0d millisecond wraps, %0d errors",
               sb.note_changes, sb.toggles, sb.ms_wraps, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("tb NOT OK");
      $finish;
   end

endmodule
